// ===== rtl/srpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constant ramp tables for the stepper ramp period generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int PERIOD_W  = 16;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int OFF_W     = 15;
  localparam int RISE_W    = 15;
  localparam int SHIFT_W   = 4;
  localparam int PROD_W    = OFF_W + RISE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT    = 1'd1;

  localparam logic [PERIOD_W-1:0] STOPPED_PERIOD      = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] FLIP_THRESHOLD_RST  = 16'd2200;
  localparam logic [COUNT_W-1:0]  STALL_LIMIT_RST     = 4'd10;
  localparam logic [PERIOD_W-1:0] ACC_END_VALUE       = 16'd575;

  localparam int ACC_N = 13;
  localparam int DEC_N = 10;

  localparam logic [PERIOD_W-1:0] ACC_BOUND [ACC_N] = '{
    16'd15, 16'd31, 16'd63, 16'd127, 16'd255, 16'd511, 16'd1023, 16'd2047,
    16'd4095, 16'd8191, 16'd16383, 16'd32767, 16'd65535};
  localparam logic [PERIOD_W-1:0] ACC_VALUE [ACC_N] = '{
    16'd15, 16'd31, 16'd62, 16'd121, 16'd218, 16'd337, 16'd437, 16'd502,
    16'd538, 16'd557, 16'd567, 16'd572, 16'd575};
  // rise into segment i and log2 of its span (all acceleration spans are powers of two)
  localparam logic [RISE_W-1:0] ACC_RISE [ACC_N] = '{
    15'd0, 15'd16, 15'd31, 15'd59, 15'd97, 15'd119, 15'd100, 15'd65,
    15'd36, 15'd19, 15'd10, 15'd5, 15'd3};
  localparam logic [SHIFT_W-1:0] ACC_SHIFT [ACC_N] = '{
    4'd0, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};

  localparam logic [PERIOD_W-1:0] DEC_BOUND [DEC_N] = '{
    16'd2, 16'd64, 16'd320, 16'd448, 16'd512, 16'd544, 16'd560, 16'd568,
    16'd572, 16'd574};
  localparam logic [PERIOD_W-1:0] DEC_VALUE [DEC_N] = '{
    16'd2, 16'd65, 16'd462, 16'd1126, 16'd2398, 16'd4848, 16'd9459, 16'd17680,
    16'd31006, 16'd49602};
  // first segment spans 62 and rises 63: for offsets below 62 the quotient
  // is the offset itself, so it is carried as rise 1, shift 0
  localparam logic [RISE_W-1:0] DEC_RISE [DEC_N] = '{
    15'd0, 15'd1, 15'd397, 15'd664, 15'd1272, 15'd2450, 15'd4611, 15'd8221,
    15'd13326, 15'd18596};
  localparam logic [SHIFT_W-1:0] DEC_SHIFT [DEC_N] = '{
    4'd0, 4'd0, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};

  typedef struct packed {
    logic                 found;
    logic [PERIOD_W-1:0]  base_val;
    logic [PERIOD_W-1:0]  base_bnd;
    logic [RISE_W-1:0]    rise;
    logic [SHIFT_W-1:0]   sh;
  } seg_t;

  // controller to datapath commands
  typedef struct packed {
    logic cap;   // capture request
    logic seg;   // state read, mode decision, segment search
    logic mul;   // offset times rise
    logic fin;   // finish, update motor state, load result
  } srpg_cmd_t;

  function automatic seg_t acc_seg(input logic [PERIOD_W-1:0] cur);
    seg_t s;
    s = '0;
    for (int i = ACC_N - 1; i >= 1; i--) begin
      if (cur < ACC_BOUND[i]) begin
        s.found    = 1'b1;
        s.base_val = ACC_VALUE[i-1];
        s.base_bnd = ACC_BOUND[i-1];
        s.rise     = ACC_RISE[i];
        s.sh       = ACC_SHIFT[i];
      end
    end
    return s;
  endfunction

  function automatic seg_t dec_seg(input logic [PERIOD_W-1:0] cur);
    seg_t s;
    s = '0;
    for (int i = DEC_N - 1; i >= 1; i--) begin
      if (cur < DEC_BOUND[i]) begin
        s.found    = 1'b1;
        s.base_val = DEC_VALUE[i-1];
        s.base_bnd = DEC_BOUND[i-1];
        s.rise     = DEC_RISE[i];
        s.sh       = DEC_SHIFT[i];
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/srpg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_ctrl
// Sequencer: walks one request through segment search, multiply and finish.
// ----------------------------------------------------------------------------
module srpg_ctrl
  import srpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output srpg_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEG  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.fin) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/srpg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_dp
// Datapath: per-motor state, table interpolation, stall rule and clamping.
// ----------------------------------------------------------------------------
module srpg_dp
  import srpg_pkg::*;
#(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srpg_cmd_t             cmd,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [1:0]            in_motor_index,
  input  logic [PERIOD_W-1:0]   in_target_period,
  input  logic                  in_target_direction,
  output logic [PERIOD_W-1:0]   out_next_period,
  output logic                  out_direction_now,
  output logic                  out_pin_level,
  output logic                  out_flipped
);

  localparam logic [2:0] MODE_OOB  = 3'd0;  // motor index beyond the store
  localparam logic [2:0] MODE_HOLD = 3'd1;  // at target
  localparam logic [2:0] MODE_DEC  = 3'd2;  // slowing toward target
  localparam logic [2:0] MODE_ACC  = 3'd3;  // speeding toward target
  localparam logic [2:0] MODE_FLIP = 3'd4;  // slow enough, flip now
  localparam logic [2:0] MODE_SLOW = 3'd5;  // too fast to flip, brake

  // configuration
  logic [PERIOD_W-1:0] flip_thr_r;
  logic [COUNT_W-1:0]  stall_lim_r;

  // per-motor state
  logic [PERIOD_W-1:0] period_r [MOTOR_COUNT];
  logic                dir_r    [MOTOR_COUNT];
  logic [COUNT_W-1:0]  cnt_r    [MOTOR_COUNT];

  // captured request
  logic [1:0]          motor_r;
  logic [PERIOD_W-1:0] tp_r;
  logic                td_r;

  // segment stage
  logic [PERIOD_W-1:0] cur_r, beyond_r, base_val_r;
  logic                dir_cur_r, found_r;
  logic [COUNT_W-1:0]  cnt_cur_r;
  logic [2:0]          mode_r;
  logic [OFF_W-1:0]    off_r;
  logic [RISE_W-1:0]   rise_r;
  logic [SHIFT_W-1:0]  sh_r;

  // multiply stage
  logic [PROD_W-1:0]   prod_r;

  // result
  logic [PERIOD_W-1:0] res_period_r;
  logic                res_dir_r, res_pin_r, res_flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_thr_r  <= FLIP_THRESHOLD_RST;
      stall_lim_r <= STALL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FLIP_THRESHOLD: flip_thr_r  <= cfg_data;
        REG_STALL_LIMIT:    stall_lim_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      motor_r <= in_motor_index;
      tp_r    <= in_target_period;
      td_r    <= in_target_direction;
    end
  end

  // ---- segment stage ----
  logic [PERIOD_W-1:0] rd_period, clamped, beyond;
  logic                rd_dir, oob, use_dec;
  logic [COUNT_W-1:0]  rd_cnt;
  logic [2:0]          mode;
  logic [PERIOD_W-1:0] off_full;
  seg_t                seg;

  always_comb begin
    rd_period = STOPPED_PERIOD;
    rd_dir    = 1'b0;
    rd_cnt    = '0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (int'(motor_r) == i) begin
        rd_period = period_r[i];
        rd_dir    = dir_r[i];
        rd_cnt    = cnt_r[i];
      end
    end
    oob = int'(motor_r) >= MOTOR_COUNT;

    if (oob)                        mode = MODE_OOB;
    else if (rd_dir == td_r) begin
      if (rd_period < tp_r)         mode = MODE_DEC;
      else if (rd_period > tp_r)    mode = MODE_ACC;
      else                          mode = MODE_HOLD;
    end
    else if (rd_period >= flip_thr_r) mode = MODE_FLIP;
    else                            mode = MODE_SLOW;

    use_dec = (mode == MODE_DEC) || (mode == MODE_SLOW);
    if (use_dec) begin
      clamped = (rd_period < DEC_BOUND[0]) ? DEC_BOUND[0] : rd_period;
      seg     = dec_seg(clamped);
    end else begin
      clamped = (rd_period < ACC_BOUND[0]) ? ACC_BOUND[0] : rd_period;
      seg     = acc_seg(clamped);
    end
    off_full = clamped - seg.base_bnd;

    if (mode == MODE_DEC)       beyond = tp_r;
    else if (mode == MODE_SLOW) beyond = STOPPED_PERIOD;
    else                        beyond = ACC_END_VALUE;
  end

  always_ff @(posedge clk) begin
    if (cmd.seg) begin
      cur_r      <= rd_period;
      dir_cur_r  <= rd_dir;
      cnt_cur_r  <= rd_cnt;
      mode_r     <= mode;
      found_r    <= seg.found;
      base_val_r <= seg.base_val;
      rise_r     <= seg.rise;
      sh_r       <= seg.sh;
      off_r      <= off_full[OFF_W-1:0];
      beyond_r   <= beyond;
    end
  end

  // ---- multiply stage ----
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(off_r) * PROD_W'(rise_r);
  end

  // ---- finish stage ----
  logic [PERIOD_W-1:0] interp, nudged, fin_period;
  logic [COUNT_W-1:0]  fin_cnt, stall_cnt;
  logic                fin_flip, fin_dir, fin_pin, up;

  always_comb begin
    interp = found_r ? (base_val_r + PERIOD_W'(prod_r >> sh_r)) : beyond_r;
    up     = (mode_r != MODE_ACC);

    // no-progress rule: nudge by one once the count reaches the limit
    nudged    = interp;
    stall_cnt = '0;
    if (interp == cur_r) begin
      if (cnt_cur_r == stall_lim_r) begin
        nudged    = up ? (interp + 16'd1) : (interp - 16'd1);
        stall_cnt = '0;
      end else begin
        stall_cnt = cnt_cur_r + 4'd1;
      end
    end

    fin_period = tp_r;
    fin_cnt    = cnt_cur_r;
    fin_flip   = 1'b0;
    unique case (mode_r)
      MODE_OOB: fin_period = STOPPED_PERIOD;
      MODE_HOLD: fin_period = tp_r;
      MODE_DEC: begin
        fin_period = (nudged > tp_r) ? tp_r : nudged;
        fin_cnt    = stall_cnt;
      end
      MODE_ACC: begin
        fin_period = (nudged < tp_r) ? tp_r : nudged;
        fin_cnt    = stall_cnt;
      end
      MODE_FLIP: begin
        fin_period = (interp < tp_r) ? tp_r : interp;
        fin_flip   = 1'b1;
      end
      MODE_SLOW: begin
        fin_cnt = stall_cnt;
        if (nudged > flip_thr_r) begin
          fin_period = flip_thr_r;
          fin_flip   = 1'b1;
        end else begin
          fin_period = nudged;
        end
      end
      default: fin_period = STOPPED_PERIOD;
    endcase

    fin_dir = (mode_r == MODE_OOB) ? 1'b0 : (fin_flip ? td_r : dir_cur_r);
    // pin is inverted on even motors
    fin_pin = (mode_r == MODE_OOB) ? 1'b0 : (motor_r[0] ? fin_dir : ~fin_dir);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (!rst_n) begin
        period_r[i] <= STOPPED_PERIOD;
        dir_r[i]    <= 1'b0;
        cnt_r[i]    <= '0;
      end else if (cmd.fin && (mode_r != MODE_OOB) && (int'(motor_r) == i)) begin
        period_r[i] <= fin_period;
        dir_r[i]    <= fin_dir;
        cnt_r[i]    <= fin_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_period_r <= fin_period;
      res_dir_r    <= fin_dir;
      res_pin_r    <= fin_pin;
      res_flip_r   <= fin_flip && (mode_r != MODE_OOB);
    end
  end

  assign out_next_period   = res_period_r;
  assign out_direction_now = res_dir_r;
  assign out_pin_level     = res_pin_r;
  assign out_flipped       = res_flip_r;

endmodule

// ===== rtl/stepper_ramp_period_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_period_generator
// Four-motor stepper ramp generator: next step period by table interpolation.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   in_      request    in_valid/in_stall   motor index, target period, direction
//   out_     result     out_valid/out_stall next period, direction, pin, flipped
//   cfg_     write      cfg_wr_en           cfg_index, cfg_data
//
// one request steps through accept, segment search, multiply and finish, with
// a single multiplier stage and a shared per-motor state update
// the next request is accepted in the cycle after the result is loaded, even
// while that result still waits on out_stall
// a result held by out_stall holds the finish stage only when a second result
// is ready; synchronous reset puts every motor at stopped (65535), direction 0
//
module stepper_ramp_period_generator
  import srpg_pkg::*;
#(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // step requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_motor_index,
  input  logic [PERIOD_W-1:0]   in_target_period,
  input  logic                  in_target_direction,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PERIOD_W-1:0]   out_next_period,
  output logic                  out_direction_now,
  output logic                  out_pin_level,
  output logic                  out_flipped
);

  srpg_cmd_t cmd;

  // sequencer
  srpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // per-motor state and interpolation datapath
  srpg_dp #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_motor_index      (in_motor_index),
    .in_target_period    (in_target_period),
    .in_target_direction (in_target_direction),
    .out_next_period     (out_next_period),
    .out_direction_now   (out_direction_now),
    .out_pin_level       (out_pin_level),
    .out_flipped         (out_flipped)
  );

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while one is in flight");

  // sequencer steps are exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.seg, cmd.mul, cmd.fin}))
    else $error("more than one sequencer step active");

  // a finished request shows up as a valid result
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid)
    else $error("finished request not presented");

  // finishing never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule
